[rtl/core/running_average_background_subtract_assert.svh]
// Assertion macros for the running average background subtractor.
`ifndef RUNNING_AVERAGE_BACKGROUND_SUBTRACT_ASSERT_SVH
`define RUNNING_AVERAGE_BACKGROUND_SUBTRACT_ASSERT_SVH
`ifndef SYNTH
`define RABS_ASSERT_IMP(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("assertion %m failed");
`define RABS_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("assertion %m failed");
`else
`define RABS_ASSERT_IMP(label, clk_sig, rst_n_sig, ante, cons)
`define RABS_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons)
`endif
`endif

[rtl/core/rabs_pkg.sv]
// Shared types and constants of the running average background subtractor.
`timescale 1ns / 1ps
package rabs_pkg;

	localparam int PIXEL_COUNT = 524288;
	localparam int IDX_W = 19;
	localparam int PIX_W = 8;
	localparam int ADDR_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam int STAT_W = 2 * PIX_W;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [STAT_W-1:0] stat_t;
	typedef logic [0:0] cfg_index_t;

	localparam cfg_index_t REG_ALPHA_WEIGHT = 1'd0;
	localparam cfg_index_t REG_FG_THRESHOLD = 1'd1;

	localparam pix_t ALPHA_RESET = 8'd51;
	localparam pix_t THRESH_RESET = 8'd50;
	localparam pix_t VAR_MAX = 8'd255;

endpackage

[rtl/core/rabs_if.sv]
// Valid/ready channel interfaces for pixels in and results out.
`timescale 1ns / 1ps
interface rabs_pixel_if import rabs_pkg::*; ();
	logic valid;
	logic ready;
	idx_t pixel_index;
	pix_t pixel_value;

	modport source (output valid, output pixel_index, output pixel_value, input ready);
	modport sink (input valid, input pixel_index, input pixel_value, output ready);
endinterface

interface rabs_result_if import rabs_pkg::*; ();
	logic valid;
	logic ready;
	logic foreground;
	pix_t new_average;
	pix_t new_variance;

	modport source (output valid, output foreground, output new_average,
		output new_variance, input ready);
	modport sink (input valid, input foreground, input new_average,
		input new_variance, output ready);
endinterface

[rtl/core/rabs_ram.sv]
// Generic single-write, single-read RAM with registered read-first output.
`timescale 1ns / 1ps
module rabs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 524288
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/running_average_background_subtract.sv]
// Running average background subtractor: top level with four-stage pipeline.
// Throughput: one pixel per cycle, unless a result held in stage 4 is not taken;
// the statistics RAM has one read and one write port.
// Reset: arst_n clears control state, loads alpha 51 and threshold 50, then a clearing
// pass writes zero to all PIXEL_COUNT (524288) RAM entries, one per cycle, with pixel
// ready held low; configuration writes are taken during that pass.
`timescale 1ns / 1ps
module running_average_background_subtract
	import rabs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  cfg_index_t    cfg_index,
	input  pix_t          cfg_data,
	rabs_pixel_if.sink    pixel,
	rabs_result_if.source result
);

	`include "running_average_background_subtract_assert.svh"

	// Configuration registers.
	pix_t       alpha_q;
	pix_t       thr_q;
	logic [8:0] alpha_inv;

	// Clearing pass state.
	logic  clear_q;
	addr_t clr_addr_q;

	// Global pipeline advance. The whole pipeline moves as one, so every item
	// keeps a fixed distance to the items ahead of it.
	logic adv;
	logic accept;
	logic in_range;
	logic pipe_busy;

	// Stage 1: pixel captured, RAM read in flight.
	logic valid_s1;
	logic inr_s1;
	idx_t idx_s1;
	pix_t x_s1;

	// Stage 2: new average known.
	logic valid_s2;
	logic inr_s2;
	idx_t idx_s2;
	pix_t x_s2;
	pix_t avg_s2;
	pix_t var_s2;

	// Stage 3: difference and its square known.
	logic        valid_s3;
	logic        inr_s3;
	idx_t        idx_s3;
	pix_t        avg_s3;
	pix_t        d_s3;
	logic [15:0] dd_s3;
	pix_t        var_s3;

	// Stage 4: complete result, held for the output transfer.
	logic valid_s4;
	logic inr_s4;
	idx_t idx_s4;
	pix_t avg_s4;
	pix_t var_s4;
	logic fg_s4;

	// RAM port signals.
	logic  ram_wr_en;
	addr_t ram_wr_addr;
	stat_t ram_wr_data;
	stat_t ram_rd_data;
	pix_t  ram_avg;
	pix_t  ram_var;

	// Combinational stage logic.
	logic        hit_s2;
	logic        hit_s3;
	logic        hit_s4;
	logic        snoop_s1;
	logic        snoop_s2;
	pix_t        avg_old;
	pix_t        var_pre;
	logic [15:0] avg_sum;
	pix_t        avg_new;
	pix_t        d_comb;
	logic [23:0] var_sum;
	pix_t        var_new;
	logic        pipe_wr;

	assign alpha_inv = 9'd256 - {1'b0, alpha_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			thr_q <= THRESH_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ALPHA_WEIGHT: alpha_q <= cfg_data;
				REG_FG_THRESHOLD: thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// After reset the RAM content is unknown, so every entry is written with
	// zero before the first pixel is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + addr_t'(1);
			if (clr_addr_q == addr_t'(PIXEL_COUNT - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	// The output register frees up when it is empty or being transferred.
	assign adv = !valid_s4 || result.ready;
	assign pixel.ready = adv && !clear_q;
	assign accept = pixel.valid && pixel.ready;

	// Pixels beyond the store use zero statistics and never touch the RAM.
	assign in_range = (32'(pixel.pixel_index) < 32'(PIXEL_COUNT));

	assign ram_avg = ram_rd_data[STAT_W-1:PIX_W];
	assign ram_var = ram_rd_data[PIX_W-1:0];

	// A pipeline item writes back when it moves from stage 3 to stage 4.
	assign pipe_wr = adv && valid_s3 && inr_s3;

	always_comb begin
		if (clear_q) begin
			ram_wr_en = 1'b1;
			ram_wr_addr = clr_addr_q;
			ram_wr_data = '0;
		end else begin
			ram_wr_en = pipe_wr;
			ram_wr_addr = addr_t'(idx_s3);
			ram_wr_data = {avg_s3, var_new};
		end
	end

	rabs_ram #(
		.WIDTH (STAT_W),
		.DEPTH (PIXEL_COUNT)
	) u_stat_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (adv),
		.rd_addr (addr_t'(pixel.pixel_index)),
		.rd_data (ram_rd_data)
	);

	// Stage 2 logic. The RAM read happened when the item entered stage 1, so
	// it misses the three items ahead of it, which have not written back yet.
	// Their new averages sit in stage registers and are forwarded, nearest first.
	assign hit_s2 = valid_s2 && inr_s2 && (idx_s2 == idx_s1);
	assign hit_s3 = valid_s3 && inr_s3 && (idx_s3 == idx_s1);
	assign hit_s4 = valid_s4 && inr_s4 && (idx_s4 == idx_s1);

	always_comb begin
		if (!inr_s1) begin
			avg_old = '0;
		end else if (hit_s2) begin
			avg_old = avg_s2;
		end else if (hit_s3) begin
			avg_old = avg_s3;
		end else if (hit_s4) begin
			avg_old = avg_s4;
		end else begin
			avg_old = ram_avg;
		end
	end

	// The variance is only needed in stage 4. Here it takes the RAM value or
	// the finished variance in stage 4; the write-back of the two nearer items
	// is picked up on the way, as they write (snoop_s1, snoop_s2).
	always_comb begin
		if (!inr_s1) begin
			var_pre = '0;
		end else if (hit_s4) begin
			var_pre = var_s4;
		end else begin
			var_pre = ram_var;
		end
	end

	assign avg_sum = 16'(alpha_q) * 16'(x_s1) + 16'(alpha_inv) * 16'(avg_old);
	assign avg_new = avg_sum[15:8];

	assign snoop_s1 = inr_s1 && valid_s3 && inr_s3 && (idx_s3 == idx_s1);
	assign snoop_s2 = inr_s2 && valid_s3 && inr_s3 && (idx_s3 == idx_s2);

	// Stage 3 logic: absolute difference to the new average.
	assign d_comb = (x_s2 > avg_s2) ? (x_s2 - avg_s2) : (avg_s2 - x_s2);

	// Stage 4 logic: weighted variance update, saturated to eight bits.
	assign var_sum = 24'(alpha_q) * 24'(dd_s3) + 24'(alpha_inv) * 24'(var_s3);
	assign var_new = (var_sum[23:16] != 8'd0) ? VAR_MAX : var_sum[15:8];

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			inr_s1 <= in_range;
			idx_s1 <= pixel.pixel_index;
			x_s1 <= pixel.pixel_value;

			inr_s2 <= inr_s1;
			idx_s2 <= idx_s1;
			x_s2 <= x_s1;
			avg_s2 <= avg_new;
			var_s2 <= snoop_s1 ? var_new : var_pre;

			inr_s3 <= inr_s2;
			idx_s3 <= idx_s2;
			avg_s3 <= avg_s2;
			d_s3 <= d_comb;
			dd_s3 <= 16'(d_comb) * 16'(d_comb);
			var_s3 <= snoop_s2 ? var_new : var_s2;

			inr_s4 <= inr_s3;
			idx_s4 <= idx_s3;
			avg_s4 <= avg_s3;
			var_s4 <= var_new;
			fg_s4 <= (d_s3 > thr_q);
		end
	end

	assign result.valid = valid_s4;
	assign result.foreground = fg_s4;
	assign result.new_average = avg_s4;
	assign result.new_variance = var_s4;

	assign pipe_busy = valid_s1 || valid_s2 || valid_s3 || valid_s4;

	// The pipeline stays empty while the clearing pass owns the RAM write port.
	`RABS_ASSERT_IMP(a_clear_pipe_empty, clk, arst_n, clear_q, !pipe_busy)
	// Once the clearing pass has finished it never starts again.
	`RABS_ASSERT_NEXT(a_clear_once, clk, arst_n, !clear_q, !clear_q)
	// Every pixel transfer occupies stage 1 in the following cycle.
	`RABS_ASSERT_NEXT(a_accept_enters, clk, arst_n, pixel.valid && pixel.ready, valid_s1)

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the running average background subtractor.
`timescale 1ns / 1ps
module testbench;
	import rabs_pkg::*;

	// The block has four pipeline stages.
	localparam int PIPE_LATENCY = 4;
	// The longest correct stretch without any transfer is the clearing pass after reset.
	// That pass touches every statistics entry once. The limit is that length three times over.
	localparam int WATCHDOG_LIMIT = 3 * PIXEL_COUNT + 10000;
	localparam int DIRECTED_ROWS = 22;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 60;
	localparam int HOT_COUNT = 6;
	localparam int PRINT_CAP = 100;

	// One result transfer, as the predictor computes it.
	typedef struct packed {
		logic foreground;
		pix_t new_average;
		pix_t new_variance;
	} bg_result_t;

	// One row of the directed table. Where typed is set, the expected result is written
	// into the row. Otherwise the predictor supplies it.
	typedef struct {
		idx_t       idx;
		pix_t       value;
		bit         typed;
		bg_result_t exp;
	} pixel_row_t;

	// The sender leaves one of these for every pixel that it offers. The monitor consumes it
	// when the pixel transfer takes place.
	typedef struct {
		bit         typed;
		bg_result_t exp;
	} pixel_note_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	cfg_index_t cfg_index;
	pix_t cfg_data;

	rabs_pixel_if pixel_ch ();
	rabs_result_if result_ch ();

	running_average_background_subtract DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel_ch),
		.result    (result_ch)
	);

	// These are the predictor's copies of the statistics.
	// An entry that was never written reads as zero.
	pix_t avg_mem [idx_t];
	pix_t var_mem [idx_t];
	pix_t alpha_q = ALPHA_RESET;
	pix_t thresh_q = THRESH_RESET;

	bg_result_t expected_results [$];
	pixel_note_t pending_notes [$];

	int mismatch_count = 0;
	int sent_count = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int stall_left = 0;
	int rx_cycle = 0;
	bit no_idle = 1'b0;

	// The directed rows run under the reset settings: alpha 51 and threshold 50.
	// The first three rows land on fresh entries, so their results can be worked out by hand.
	// A zero pixel leaves everything at zero. A full-scale pixel gives an average of 50 and a
	// difference of 205. That difference makes the variance saturate and the pixel foreground.
	// The rows for entries 2 and 3 put the difference exactly on the threshold and one above it.
	pixel_row_t directed_rows [DIRECTED_ROWS] = '{
		'{19'd0,       8'd0,   1'b1, '{1'b0, 8'd0,  8'd0}},
		'{19'd1,       8'd255, 1'b1, '{1'b1, 8'd50, 8'd255}},
		'{19'h7FFFF,   8'd255, 1'b1, '{1'b1, 8'd50, 8'd255}},
		'{19'h7FFFF,   8'd255, 1'b0, '0},
		'{19'h7FFFF,   8'd0,   1'b0, '0},
		'{19'd2,       8'd62,  1'b0, '0},
		'{19'd3,       8'd63,  1'b0, '0},
		'{19'd4,       8'd200, 1'b0, '0},
		'{19'd4,       8'd200, 1'b0, '0},
		'{19'd4,       8'd200, 1'b0, '0},
		'{19'd4,       8'd200, 1'b0, '0},
		'{19'd4,       8'd200, 1'b0, '0},
		'{19'd4,       8'd200, 1'b0, '0},
		'{19'd4,       8'd0,   1'b0, '0},
		'{19'd5,       8'd128, 1'b0, '0},
		'{19'd5,       8'd129, 1'b0, '0},
		'{19'd5,       8'd127, 1'b0, '0},
		'{19'd5,       8'd128, 1'b0, '0},
		'{19'h55555,   8'd170, 1'b0, '0},
		'{19'h2AAAA,   8'd85,  1'b0, '0},
		'{19'd0,       8'd255, 1'b0, '0},
		'{19'd1,       8'd0,   1'b0, '0}
	};

	// These are the settings of the random phases.
	// The last two phases draw their settings at random.
	// Alpha zero is included: the average and the variance then keep their stored values.
	pix_t phase_alpha [RANDOM_PHASES] = '{8'd255, 8'd0, 8'd1, 8'd51, 8'd128, 8'd200, 8'd0, 8'd0};
	pix_t phase_thresh [RANDOM_PHASES] = '{8'd0, 8'd255, 8'd255, 8'd50, 8'd20, 8'd0, 8'd0, 8'd0};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// This is the predictor. It updates the running average and the variance of one pixel and
	// writes both back to the statistics copies.
	function automatic bg_result_t update_pixel_stats(idx_t idx, pix_t x);
		int unsigned a;
		int unsigned na;
		int unsigned old_avg;
		int unsigned old_var;
		int unsigned new_avg;
		int unsigned diff;
		int unsigned new_var;
		bit in_range;
		bg_result_t r;
		a = alpha_q;
		na = 256 - a;
		in_range = (idx < PIXEL_COUNT);
		old_avg = 0;
		old_var = 0;
		// An index beyond the frame neither reads nor writes the stores. It sees zero statistics.
		if (in_range && avg_mem.exists(idx)) begin
			old_avg = avg_mem[idx];
			old_var = var_mem[idx];
		end
		new_avg = (a * x + na * old_avg) >> 8;
		diff = (x > new_avg) ? (x - new_avg) : (new_avg - x);
		new_var = (a * diff * diff + na * old_var) >> 8;
		if (new_var > VAR_MAX)
			new_var = VAR_MAX;
		if (in_range) begin
			avg_mem[idx] = pix_t'(new_avg);
			var_mem[idx] = pix_t'(new_var);
		end
		r.foreground = (diff > thresh_q);
		r.new_average = pix_t'(new_avg);
		r.new_variance = pix_t'(new_var);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// This task offers one pixel and returns at the edge where its transfer takes place.
	// The sender works in bursts. When a burst is used up outside a no-idle phase, valid drops
	// before the next burst starts. Because of that, valid never falls and rises in the same
	// time step.
	task automatic send_pixel(idx_t idx, pix_t val, bit typed, bg_result_t exp);
		pixel_note_t note;
		if (burst_left == 0) begin
			if (!no_idle) begin
				pixel_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
		end
		note.typed = typed;
		note.exp = exp;
		pending_notes.push_back(note);
		pixel_ch.valid <= 1'b1;
		pixel_ch.pixel_index <= idx;
		pixel_ch.pixel_value <= val;
		do
			@(posedge clk);
		while (!pixel_ch.ready);
		sent_count++;
		burst_left--;
	endtask

	// This task stops offering pixels and waits until every transfer has returned its result.
	// It then waits for the pipeline latency and a margin, so the pipeline is empty before any setting changes.
	task automatic drain_pipeline();
		pixel_ch.valid <= 1'b0;
		while (results_seen != sent_count)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// The registers may only be written while the pipeline is empty. The predictor follows the
	// write once it has been applied.
	task automatic write_settings(pix_t alpha, pix_t thresh);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_ALPHA_WEIGHT;
		cfg_data <= alpha;
		@(posedge clk);
		cfg_index <= REG_FG_THRESHOLD;
		cfg_data <= thresh;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		alpha_q = alpha;
		thresh_q = thresh;
	endtask

	// The receiver stalls on its own pattern. Short random stalls are mixed with longer periodic
	// stalls. In a no-idle phase the receiver is always ready.
	always @(posedge clk) begin
		rx_cycle++;
		if (no_idle) begin
			result_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			if (rx_cycle % 97 == 0)
				stall_left = 12;
			else if ($urandom_range(0, 9) < 3)
				stall_left = $urandom_range(1, 6);
		end
	end

	// The monitor watches both channels in one process. A result is checked against the oldest
	// expectation first. A pixel transfer then adds its own expectation at the back.
	// Because of that order, the outcome does not depend on how processes are scheduled
	// within the edge.
	always @(posedge clk) begin : monitor
		bg_result_t exp;
		bg_result_t pred;
		pixel_note_t note;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (result_ch.valid && result_ch.ready) begin
				moved = 1'b1;
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("result transfer with no pixel pending");
				end else begin
					exp = expected_results.pop_front();
					if (result_ch.foreground !== exp.foreground)
						report_mismatch($sformatf("foreground got %0b want %0b",
							result_ch.foreground, exp.foreground));
					if (result_ch.new_average !== exp.new_average)
						report_mismatch($sformatf("new_average got %0d want %0d",
							result_ch.new_average, exp.new_average));
					if (result_ch.new_variance !== exp.new_variance)
						report_mismatch($sformatf("new_variance got %0d want %0d",
							result_ch.new_variance, exp.new_variance));
				end
			end
			if (pixel_ch.valid && pixel_ch.ready) begin
				moved = 1'b1;
				note = pending_notes.pop_front();
				pred = update_pixel_stats(pixel_ch.pixel_index, pixel_ch.pixel_value);
				expected_results.push_back(note.typed ? note.exp : pred);
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// The watchdog ends a run that has stopped making progress.
	initial begin : watchdog
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("[running_average_background_subtract] ERROR");
		$finish;
	end

	initial begin : main
		idx_t idx;
		idx_t hot [HOT_COUNT];
		pix_t cur;
		pix_t alpha;
		pix_t thresh;
		int v;
		int p;
		int i;
		int k;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_ALPHA_WEIGHT;
		cfg_data <= '0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.pixel_index <= '0;
		pixel_ch.pixel_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// The directed table comes first. The clearing pass holds pixel ready low, so the first
		// transfer waits until the pass is over.
		for (i = 0; i < DIRECTED_ROWS; i++)
			send_pixel(directed_rows[i].idx, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].exp);
		drain_pipeline();

		// The random phases follow. Most pixels revisit a small set of entries, so the averages
		// and variances build up over many updates. The pixel values stay mostly close to the
		// current average, with jumps to the extremes mixed in. The other pixels land anywhere
		// in the frame, so every index bit takes both values.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			alpha = (p >= 6) ? pix_t'($urandom_range(0, 255)) : phase_alpha[p];
			thresh = (p >= 6) ? pix_t'($urandom_range(0, 255)) : phase_thresh[p];
			write_settings(alpha, thresh);
			no_idle = (p == 3);
			for (k = 0; k < HOT_COUNT; k++)
				hot[k] = idx_t'($urandom);
			hot[0] = (p % 2) ? '1 : '0;
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 9) < 7) begin
					idx = hot[$urandom_range(0, HOT_COUNT - 1)];
					cur = avg_mem.exists(idx) ? avg_mem[idx] : '0;
					case ($urandom_range(0, 9))
						0: v = 0;
						1: v = 255;
						2, 3: v = $urandom_range(0, 255);
						default: v = int'(cur) + int'($urandom_range(0, 24)) - 12;
					endcase
					if (v < 0)
						v = 0;
					if (v > 255)
						v = 255;
				end else begin
					idx = idx_t'($urandom);
					v = $urandom_range(0, 255);
				end
				send_pixel(idx, pix_t'(v), 1'b0, '0);
			end
			drain_pipeline();
			no_idle = 1'b0;
		end

		if (mismatch_count == 0)
			$display("[running_average_background_subtract] OK");
		else
			$display("[running_average_background_subtract] ERROR");
		$finish;
	end

endmodule
